@@ sv/rcs_pkg.sv @@
`timescale 1ns / 1ps

package rcs_pkg;

    localparam int MAX_DEGREE_DEF  = 1024;
    localparam int TABLE_DEPTH_DEF = 16;
    localparam int COEFF_BITS      = 16;
    localparam int WORD_BITS       = 64;
    localparam int RING_W          = 11;
    localparam int CB_W            = 5;
    localparam int LIM_W           = 5;
    localparam int CFG_W           = 11;
    localparam int CFG_IDX_W       = 2;
    localparam int IDX_W           = 10;
    localparam int TIDX_W          = 4;
    localparam int CHUNK_W         = 16;
    localparam int LEFT_W          = 6;

    localparam logic [RING_W-1:0] RING_RST  = 11'd1024;
    localparam logic [CB_W-1:0]   CB_RST    = 5'd4;
    localparam logic [LIM_W-1:0]  LIM_RST   = 5'd11;
    localparam logic [CB_W-1:0]   CB_MIN    = 5'd2;
    localparam logic [CB_W-1:0]   CB_MAX    = 5'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RING_SIZE    = 2'd0,
        CFG_CHUNK_BITS   = 2'd1,
        CFG_ACCEPT_LIMIT = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ZERO,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic tbl_wr;
        logic load;
        logic step;
        logic push;
        logic run_last;
        logic pend_zero;
        logic pend_clr;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
        logic poly_last;
        logic ring_odd;
        logic last_chunk;
        logic pend_valid;
        logic out_free;
    } t_dp_stat;

    // ceil(64 / cb) for a clamped chunk width
    function automatic logic [LEFT_W-1:0] chunk_count(input logic [CB_W-1:0] cb);
        logic [LEFT_W-1:0] n;
        case (cb)
            5'd2:    n = 6'd32;
            5'd3:    n = 6'd22;
            5'd4:    n = 6'd16;
            5'd5:    n = 6'd13;
            5'd6:    n = 6'd11;
            5'd7:    n = 6'd10;
            5'd8:    n = 6'd8;
            5'd9:    n = 6'd8;
            5'd10:   n = 6'd7;
            5'd11:   n = 6'd6;
            5'd12:   n = 6'd6;
            5'd13:   n = 6'd5;
            5'd14:   n = 6'd5;
            5'd15:   n = 6'd5;
            5'd16:   n = 6'd4;
            default: n = 6'd4;
        endcase
        return n;
    endfunction

endpackage

@@ sv/rcs_ctrl.sv @@
`timescale 1ns / 1ps

module rcs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_mode,
    input  rcs_pkg::t_dp_stat i_stat,
    output logic              o_in_stall,
    output rcs_pkg::t_dp_cmd  o_cmd
);

    rcs_pkg::t_state r_state;
    rcs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        o_cmd      = '0;
        case (r_state)
            rcs_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_mode) begin
                        o_cmd.tbl_wr = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = rcs_pkg::ST_SCAN;
                    end
                end
            end
            rcs_pkg::ST_SCAN: begin
                // advance one chunk only when a push can land
                if (i_stat.out_free) begin
                    o_cmd.step = 1'b1;
                    o_cmd.push = i_stat.hit && i_stat.pend_valid;
                    if (i_stat.hit && i_stat.poly_last) begin
                        n_state = i_stat.ring_odd ? rcs_pkg::ST_ZERO : rcs_pkg::ST_FLUSH;
                    end else if (i_stat.last_chunk) begin
                        n_state = rcs_pkg::ST_FLUSH;
                    end
                end
            end
            rcs_pkg::ST_ZERO: begin
                if (i_stat.out_free) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.pend_zero = 1'b1;
                    n_state         = rcs_pkg::ST_FLUSH;
                end
            end
            rcs_pkg::ST_FLUSH: begin
                if (!i_stat.pend_valid) begin
                    n_state = rcs_pkg::ST_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.push     = 1'b1;
                    o_cmd.run_last = 1'b1;
                    o_cmd.pend_clr = 1'b1;
                    n_state        = rcs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rcs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ sv/rcs_dp.sv @@
`timescale 1ns / 1ps

module rcs_dp #(
    parameter int MAX_DEGREE  = rcs_pkg::MAX_DEGREE_DEF,
    parameter int TABLE_DEPTH = rcs_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rcs_pkg::t_dp_cmd                 i_cmd,
    output rcs_pkg::t_dp_stat                o_stat,
    input  logic                             i_cfg_wr_en,
    input  logic [rcs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rcs_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic [rcs_pkg::WORD_BITS-1:0]    i_random_word,
    input  logic [rcs_pkg::TIDX_W-1:0]       i_table_index,
    input  logic [rcs_pkg::COEFF_BITS-1:0]   i_table_value,
    input  logic                             i_out_stall,
    output logic                             o_out_valid,
    output logic [rcs_pkg::COEFF_BITS-1:0]   o_coefficient,
    output logic [rcs_pkg::IDX_W-1:0]        o_coeff_index,
    output logic                             o_poly_done,
    output logic                             o_run_last
);

    localparam int CNT_W  = $clog2(MAX_DEGREE + 1);
    localparam int TBL_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // configuration
    logic [rcs_pkg::RING_W-1:0] r_ring;
    logic [rcs_pkg::CB_W-1:0]   r_cb;
    logic [rcs_pkg::LIM_W-1:0]  r_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring <= rcs_pkg::RING_RST;
            r_cb   <= rcs_pkg::CB_RST;
            r_lim  <= rcs_pkg::LIM_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                rcs_pkg::CFG_RING_SIZE:    r_ring <= i_cfg_data;
                rcs_pkg::CFG_CHUNK_BITS:   r_cb   <= i_cfg_data[rcs_pkg::CB_W-1:0];
                rcs_pkg::CFG_ACCEPT_LIMIT: r_lim  <= i_cfg_data[rcs_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped working values
    logic [CNT_W-1:0]            w_m;
    logic [CNT_W-1:0]            w_loop_limit;
    logic                        w_odd;
    logic [rcs_pkg::CB_W-1:0]    w_cb;
    logic [rcs_pkg::CHUNK_W-1:0] w_lim;

    always_comb begin
        if (r_ring < rcs_pkg::RING_W'(2)) begin
            w_m = CNT_W'(2);
        end else if (32'(r_ring) > MAX_DEGREE) begin
            w_m = CNT_W'(MAX_DEGREE);
        end else begin
            w_m = CNT_W'(r_ring);
        end
        w_odd        = w_m[0];
        w_loop_limit = w_odd ? (w_m - CNT_W'(1)) : w_m;
        if (r_cb < rcs_pkg::CB_MIN) begin
            w_cb = rcs_pkg::CB_MIN;
        end else if (r_cb > rcs_pkg::CB_MAX) begin
            w_cb = rcs_pkg::CB_MAX;
        end else begin
            w_cb = r_cb;
        end
        w_lim = (32'(r_lim) > TABLE_DEPTH) ? rcs_pkg::CHUNK_W'(TABLE_DEPTH)
                                           : rcs_pkg::CHUNK_W'(r_lim);
    end

    // word shifter and chunk test
    logic [rcs_pkg::WORD_BITS-1:0] r_word;
    logic [rcs_pkg::LEFT_W-1:0]    r_left;
    logic [CNT_W-1:0]              r_count;
    logic [rcs_pkg::CHUNK_W-1:0]   w_mask;
    logic [rcs_pkg::CHUNK_W-1:0]   w_chunk;
    logic                          w_hit;
    logic                          w_poly_last;

    assign w_mask      = rcs_pkg::CHUNK_W'((17'd1 << w_cb) - 17'd1);
    assign w_chunk     = r_word[rcs_pkg::CHUNK_W-1:0] & w_mask;
    assign w_hit       = w_chunk < w_lim;
    assign w_poly_last = (r_count + CNT_W'(1)) == w_loop_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_left  <= '0;
        end else if (i_cmd.load) begin
            r_left <= rcs_pkg::chunk_count(w_cb);
            // drop a count left stale by a ring size change
            if (r_count >= w_loop_limit) begin
                r_count <= '0;
            end
        end else if (i_cmd.step) begin
            r_left <= r_left - rcs_pkg::LEFT_W'(1);
            if (w_hit) begin
                r_count <= w_poly_last ? '0 : (r_count + CNT_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word <= i_random_word;
        end else if (i_cmd.step) begin
            r_word <= r_word >> w_cb;
        end
    end

    // coefficient table
    logic [rcs_pkg::COEFF_BITS-1:0] r_mem [TABLE_DEPTH];
    logic [rcs_pkg::COEFF_BITS-1:0] r_rd_data;
    logic [TBL_AW+rcs_pkg::TIDX_W-1:0] w_widx;
    logic                           w_wr_ok;

    assign w_widx  = (TBL_AW + rcs_pkg::TIDX_W)'(i_table_index);
    assign w_wr_ok = 32'(i_table_index) < TABLE_DEPTH;

    always_ff @(posedge i_clk) begin
        if (i_cmd.tbl_wr && w_wr_ok) begin
            r_mem[w_widx[TBL_AW-1:0]] <= i_table_value;
        end
        if (i_cmd.step && w_hit) begin
            r_rd_data <= r_mem[w_chunk[TBL_AW-1:0]];
        end
    end

    // pending result: held until the next hit or the end of the word
    logic             r_pend_valid;
    logic             r_pend_zero;
    logic             r_pend_done;
    logic [CNT_W-1:0] r_pend_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.pend_clr) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.pend_zero || (i_cmd.step && w_hit)) begin
            r_pend_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pend_zero) begin
            r_pend_zero <= 1'b1;
            r_pend_done <= 1'b1;
            r_pend_idx  <= w_loop_limit;
        end else if (i_cmd.step && w_hit) begin
            r_pend_zero <= 1'b0;
            r_pend_done <= w_poly_last && !w_odd;
            r_pend_idx  <= r_count;
        end
    end

    // output register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            o_coefficient <= r_pend_zero ? '0 : r_rd_data;
            o_coeff_index <= rcs_pkg::IDX_W'(r_pend_idx);
            o_poly_done   <= r_pend_done;
            o_run_last    <= i_cmd.run_last;
        end
    end

    assign o_out_valid = r_out_valid;

    assign o_stat.hit        = w_hit;
    assign o_stat.poly_last  = w_poly_last;
    assign o_stat.ring_odd   = w_odd;
    assign o_stat.last_chunk = r_left == rcs_pkg::LEFT_W'(1);
    assign o_stat.pend_valid = r_pend_valid;
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

endmodule

@@ sv/rejection_coeff_sampler_top.sv @@
// Rejection sampler for small ring coefficients. Each mode 0 word is a 64-bit
// random value cut into chunk_bits-wide chunks from the low end; a chunk below
// accept_limit picks an entry of the coefficient table, which comes out with its
// position, and the last word of a polynomial carries poly_done. An odd
// ring_size appends a zero coefficient at position ring_size-1. run_last marks
// the final word a given input produced. Mode 1 inputs load one table entry and
// produce nothing; load every entry that accept_limit can reach before sampling.
// One chunk is tested per cycle while the result register can take a push, so
// a mode 0 input holds the block for its scan of up to ceil(64/chunk_bits)
// chunks, then for an odd ring the zero word, then the end of word flush,
// before the idle state takes the next input; a polynomial that completes
// mid-word ends the scan early. A mode 1 input leaves the block idle and ready
// for the next input. One held word plus the result register let the scan emit
// one coefficient per cycle while the receiver keeps up; each cycle in which the
// result register is full and stalled halts the scan, the zero word and the
// flush. Configuration may be written only while the block is idle.
`timescale 1ns / 1ps

module rejection_coeff_sampler_top #(
    parameter int MAX_DEGREE  = rcs_pkg::MAX_DEGREE_DEF,
    parameter int TABLE_DEPTH = rcs_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_wr_en,
    input  logic [rcs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rcs_pkg::CFG_W-1:0]        i_cfg_data,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_mode,
    input  logic [rcs_pkg::WORD_BITS-1:0]    i_random_word,
    input  logic [rcs_pkg::TIDX_W-1:0]       i_table_index,
    input  logic [rcs_pkg::COEFF_BITS-1:0]   i_table_value,
    // output channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [rcs_pkg::COEFF_BITS-1:0]   o_coefficient,
    output logic [rcs_pkg::IDX_W-1:0]        o_coeff_index,
    output logic                             o_poly_done,
    output logic                             o_run_last
);

    rcs_pkg::t_dp_cmd  w_cmd;
    rcs_pkg::t_dp_stat w_stat;

    // sequencer: idle, scan chunks, append the zero word, flush the held word
    rcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_stat     (w_stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    // datapath: config, word shifter, count, table, held word, output register
    rcs_dp #(
        .MAX_DEGREE  (MAX_DEGREE),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_random_word (i_random_word),
        .i_table_index (i_table_index),
        .i_table_value (i_table_value),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_coefficient (o_coefficient),
        .o_coeff_index (o_coeff_index),
        .o_poly_done   (o_poly_done),
        .o_run_last    (o_run_last)
    );

    // a new input is taken only once the previous one has left no held word
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !w_stat.pend_valid)
        else $error("input taken while a word is still held");

    // never overwrite an undelivered result
    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |-> w_stat.out_free)
        else $error("result pushed into a full output register");

    // completing a polynomial ends the word's results
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_poly_done |-> o_run_last)
        else $error("poly_done without run_last");

endmodule
